/* rtl/scalar_kalman_filter_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scalar Kalman filter
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_TOP_MACROS_SVH
`define SCALAR_KALMAN_FILTER_TOP_MACROS_SVH

// Same-cycle implication.
`define SKF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and Q16.16 saturation helpers of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  typedef logic signed [31:0] q16_t;

  localparam q16_t QMax = 32'sh7fff_ffff;
  localparam q16_t QMin = 32'sh8000_0000;
  localparam q16_t One  = 32'sh0001_0000;

  // Multiplier: one 4-bit digit of the multiplier per cycle.
  localparam int unsigned MulDigitW = 4;
  localparam int unsigned MulSteps  = 32 / MulDigitW;
  localparam int unsigned MulCntW   = $clog2(MulSteps);

  // Divider: one quotient bit per cycle over a 48-bit dividend.
  localparam int unsigned DivSteps = 48;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register map.
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    REG_Q  = 3'd0,
    REG_R  = 3'd1,
    REG_A  = 3'd2,
    REG_H  = 3'd3,
    REG_P0 = 3'd4
  } cfg_reg_e;

  localparam logic [30:0] ResetQ  = 31'd131072;
  localparam logic [30:0] ResetR  = 31'd5242880;
  localparam q16_t        ResetA  = 32'sd65536;
  localparam q16_t        ResetH  = 32'sd65536;
  localparam logic [30:0] ResetP0 = 31'd64225280;

  // Request and response of an arithmetic unit.
  typedef struct packed {
    logic start;
    q16_t op_a;
    q16_t op_b;
  } op_req_t;

  typedef struct packed {
    logic done;
    q16_t res;
  } op_rsp_t;

  function automatic logic [31:0] magnitude(q16_t v);
    logic [32:0] neg;
    neg = 33'd0 - {v[31], v};
    return v[31] ? neg[31:0] : v;
  endfunction

  // Applies a sign to an unsigned magnitude and saturates; big flags a
  // magnitude of 2^32 or more.
  function automatic q16_t sat_mag(logic big, logic [31:0] r, logic neg);
    q16_t res;
    if (big || r[31]) begin
      res = neg ? QMin : QMax;
    end else begin
      res = neg ? -$signed(r) : $signed(r);
    end
    return res;
  endfunction

  function automatic q16_t sat_add(q16_t a, q16_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? QMin : QMax;
    end
    return s[31:0];
  endfunction

  function automatic q16_t sat_sub(q16_t a, q16_t b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? QMin : QMax;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/scalar_kalman_filter_top.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// One-dimensional Kalman filter in signed Q16.16 with a digit-serial
// multiplier and a bit-serial divider under a step sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[31:0] measurement
//  m_axis    out        tdata[31:0] estimate, tdata[63:32] gain
//  cfg       in         cfg_index_i register index, cfg_data_i value
//
//  Output valid follows an input beat after eight multiplies on the shared
//  4-bit digit multiplier, one divide (one quotient bit per cycle over 48
//  bits) and the output load. The next measurement is taken only once the
//  sequencer is back in idle, after the last result was loaded. A waiting
//  result does not block the next input; a stalled output holds the
//  sequencer in its output step. Reset loads the defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_top_macros.svh"

module scalar_kalman_filter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // [31:0] measurement
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [63:0]                  m_axis_tdata,   // [31:0] estimate, [63:32] gain
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [skf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X,
    ST_AA,
    ST_AP,
    ST_PH,
    ST_PHH,
    ST_DIV,
    ST_DK,
    ST_KH,
    ST_UP,
    ST_OUT
  } state_e;

  state_e        state_q;
  logic [30:0]   q_q;
  logic [30:0]   r_q;
  skf_pkg::q16_t a_q;
  skf_pkg::q16_t h_q;
  skf_pkg::q16_t est_q;
  skf_pkg::q16_t var_q;
  logic          m_valid_q;

  skf_pkg::q16_t z_q;
  skf_pkg::q16_t x_q;
  skf_pkg::q16_t p_q;
  skf_pkg::q16_t ph_q;
  skf_pkg::q16_t k_q;
  logic [63:0]   m_data_q;

  skf_pkg::op_req_t mul_req;
  skf_pkg::op_rsp_t mul_rsp;
  skf_pkg::op_req_t div_req;
  skf_pkg::op_rsp_t div_rsp;

  logic          s_accept;
  logic          out_load;
  skf_pkg::q16_t p_w;
  skf_pkg::q16_t den_w;
  skf_pkg::q16_t est_w;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign p_w      = skf_pkg::sat_add(mul_rsp.res, {1'b0, q_q});
  assign den_w    = skf_pkg::sat_add(mul_rsp.res, {1'b0, r_q});
  assign est_w    = skf_pkg::sat_add(x_q, mul_rsp.res);

  skf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  skf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Each step launches the next operation in the cycle its result arrives.
  always_comb begin
    mul_req = '0;
    div_req = '0;
    unique case (state_q)
      ST_IDLE: if (s_accept)     mul_req = '{1'b1, a_q, est_q};
      ST_X:    if (mul_rsp.done) mul_req = '{1'b1, a_q, a_q};
      ST_AA:   if (mul_rsp.done) mul_req = '{1'b1, mul_rsp.res, var_q};
      ST_AP:   if (mul_rsp.done) mul_req = '{1'b1, p_w, h_q};
      ST_PH:   if (mul_rsp.done) mul_req = '{1'b1, mul_rsp.res, h_q};
      ST_PHH:  if (mul_rsp.done) div_req = '{1'b1, ph_q, den_w};
      ST_DIV: begin
        if (div_rsp.done) begin
          mul_req = '{1'b1, skf_pkg::sat_sub(z_q, x_q), div_rsp.res};
        end
      end
      ST_DK:   if (mul_rsp.done) mul_req = '{1'b1, k_q, h_q};
      ST_KH: begin
        if (mul_rsp.done) begin
          mul_req = '{1'b1, skf_pkg::sat_sub(skf_pkg::One, mul_rsp.res), p_q};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      q_q       <= skf_pkg::ResetQ;
      r_q       <= skf_pkg::ResetR;
      a_q       <= skf_pkg::ResetA;
      h_q       <= skf_pkg::ResetH;
      est_q     <= '0;
      var_q     <= {1'b0, skf_pkg::ResetP0};
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          skf_pkg::REG_Q:  q_q <= cfg_data_i[30:0];
          skf_pkg::REG_R:  r_q <= cfg_data_i[30:0];
          skf_pkg::REG_A:  a_q <= cfg_data_i;
          skf_pkg::REG_H:  h_q <= cfg_data_i;
          skf_pkg::REG_P0: begin
            var_q <= {1'b0, cfg_data_i[30:0]};
          end
          default: begin
          end
        endcase
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {k_q, est_q};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: if (s_accept)     state_q <= ST_X;
        ST_X:    if (mul_rsp.done) state_q <= ST_AA;
        ST_AA:   if (mul_rsp.done) state_q <= ST_AP;
        ST_AP:   if (mul_rsp.done) state_q <= ST_PH;
        ST_PH:   if (mul_rsp.done) state_q <= ST_PHH;
        ST_PHH:  if (mul_rsp.done) state_q <= ST_DIV;
        ST_DIV:  if (div_rsp.done) state_q <= ST_DK;
        ST_DK: begin
          if (mul_rsp.done) begin
            est_q   <= est_w;
            state_q <= ST_KH;
          end
        end
        ST_KH:   if (mul_rsp.done) state_q <= ST_UP;
        ST_UP: begin
          if (mul_rsp.done) begin
            var_q   <= mul_rsp.res;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      z_q <= s_axis_tdata;
    end
    if (mul_rsp.done && (state_q == ST_X)) begin
      x_q <= mul_rsp.res;
    end
    if (mul_rsp.done && (state_q == ST_AP)) begin
      p_q <= p_w;
    end
    if (mul_rsp.done && (state_q == ST_PH)) begin
      ph_q <= mul_rsp.res;
    end
    if (div_rsp.done && (state_q == ST_DIV)) begin
      k_q <= div_rsp.res;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  `SKF_ASSERT_IMPL(a_one_unit_busy, mul_req.start, !div_req.start, "multiply and divide launched together")
  `SKF_ASSERT_NEXT(a_out_loaded, out_load, m_valid_q && (state_q == ST_IDLE), "result not presented after final step")

endmodule

`default_nettype wire

/* rtl/skf_mul.sv */
// ----------------------------------------------------------------------------
// skf_mul
// Digit-serial Q16.16 multiplier: 4 bits of the multiplier per cycle,
// followed by rounding to nearest and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_top_macros.svh"

module skf_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  skf_pkg::op_req_t req_i,
  output skf_pkg::op_rsp_t rsp_o
);

  logic [31:0]                  mcand_q;
  logic [31:0]                  hi_q;
  logic [31:0]                  lo_q;
  logic                         neg_q;
  logic                         busy_q;
  logic                         fin_q;
  logic                         done_q;
  logic [skf_pkg::MulCntW-1:0]  cnt_q;
  skf_pkg::q16_t                res_q;

  logic [35:0] dsum;
  logic [63:0] rnd;

  // Partial product of one digit added to the running upper half.
  assign dsum = {4'd0, hi_q} + mcand_q * lo_q[skf_pkg::MulDigitW-1:0];
  assign rnd  = {hi_q, lo_q} + 64'h0000_0000_0000_8000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q  <= busy_q && (cnt_q == skf_pkg::MulCntW'(skf_pkg::MulSteps - 1));
      done_q <= fin_q;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == skf_pkg::MulCntW'(skf_pkg::MulSteps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= skf_pkg::magnitude(req_i.op_a);
      lo_q    <= skf_pkg::magnitude(req_i.op_b);
      hi_q    <= '0;
      neg_q   <= req_i.op_a[31] ^ req_i.op_b[31];
    end else if (busy_q) begin
      hi_q <= dsum[35:4];
      lo_q <= {dsum[3:0], lo_q[31:4]};
    end
    if (fin_q) begin
      res_q <= skf_pkg::sat_mag(|rnd[63:48], rnd[47:16], neg_q);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  `SKF_ASSERT_IMPL(a_mul_no_overlap, req_i.start, !busy_q && !fin_q, "multiply started while busy")
  `SKF_ASSERT_NEXT(a_mul_done_pulse, done_q, !done_q, "multiply done held longer than one cycle")

endmodule

`default_nettype wire

/* rtl/skf_div.sv */
// ----------------------------------------------------------------------------
// skf_div
// Bit-serial restoring divider for Q16.16: one quotient bit per cycle,
// rounded to nearest, saturated, zero for a zero divisor.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scalar_kalman_filter_top_macros.svh"

module skf_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  skf_pkg::op_req_t req_i,
  output skf_pkg::op_rsp_t rsp_o
);

  logic [31:0]                  md_q;
  logic [47:0]                  num_q;
  logic [31:0]                  rem_q;
  logic [31:0]                  quo_q;
  logic                         big_q;
  logic                         neg_q;
  logic                         dz_q;
  logic                         busy_q;
  logic                         fin_q;
  logic                         done_q;
  logic [skf_pkg::DivCntW-1:0]  cnt_q;
  skf_pkg::q16_t                res_q;

  logic [31:0] md_w;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;

  assign md_w   = skf_pkg::magnitude(req_i.op_b);
  assign rem_sh = {rem_q, num_q[47]};
  assign diff   = rem_sh - {1'b0, md_q};
  assign ge     = rem_sh >= {1'b0, md_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q  <= busy_q && (cnt_q == skf_pkg::DivCntW'(skf_pkg::DivSteps - 1));
      done_q <= fin_q;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == skf_pkg::DivCntW'(skf_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      md_q  <= md_w;
      // Half the divisor is added up front for round to nearest.
      num_q <= {skf_pkg::magnitude(req_i.op_a), 16'd0} + {17'd0, md_w[31:1]};
      rem_q <= '0;
      quo_q <= '0;
      big_q <= 1'b0;
      neg_q <= req_i.op_a[31] ^ req_i.op_b[31];
      dz_q  <= (req_i.op_b == '0);
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
      num_q <= {num_q[46:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
      big_q <= big_q | quo_q[31];
    end
    if (fin_q) begin
      res_q <= dz_q ? '0 : skf_pkg::sat_mag(big_q, quo_q, neg_q);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  `SKF_ASSERT_IMPL(a_div_no_overlap, req_i.start, !busy_q && !fin_q, "divide started while busy")

endmodule

`default_nettype wire
